// ===== hdl/sbpc_pkg.sv =====
package sbpc_pkg;

    localparam int THR_W  = 10;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [THR_W-1:0] LONG_THR_RESET  = 10'd250;
    localparam logic [THR_W-1:0] SHORT_THR_RESET = 10'd2;

    // register index, taken from paddr[2]
    localparam logic REG_LONG_THR  = 1'b0;
    localparam logic REG_SHORT_THR = 1'b1;

    localparam logic [2:0] BTN_NONE = 3'd0;
    localparam logic [2:0] BTN_DEC  = 3'd1;
    localparam logic [2:0] BTN_INC  = 3'd2;
    localparam logic [2:0] BTN_MODE = 3'd3;
    localparam logic [2:0] BTN_OUT  = 3'd4;

    typedef enum logic [1:0] {
        PH_LEFT   = 2'd0,
        PH_CENTER = 2'd1,
        PH_RIGHT  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_SHORT   = 2'd1,
        KIND_LONG    = 2'd2,
        KIND_RELEASE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [THR_W-1:0] long_threshold;
        logic [THR_W-1:0] short_threshold;
    } thr_t;

endpackage

// ===== hdl/sbpc_if.sv =====
interface sbpc_tick_if;
    logic valid;
    logic ready;
    logic sense_level;

    modport source (output valid, output sense_level, input ready);
    modport sink (input valid, input sense_level, output ready);
endinterface

interface sbpc_report_if;
    logic       valid;
    logic       ready;
    logic [1:0] scan_phase;
    logic       report_valid;
    logic [2:0] button_id;
    logic [1:0] press_kind;

    modport source (output valid, output scan_phase, output report_valid,
                    output button_id, output press_kind, input ready);
    modport sink (input valid, input scan_phase, input report_valid,
                  input button_id, input press_kind, output ready);
endinterface

// ===== hdl/sbpc_regs.sv =====
module sbpc_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbpc_pkg::DATA_W-1:0]  pwdata,
    output logic [sbpc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output sbpc_pkg::thr_t               thr
);

    logic [sbpc_pkg::THR_W-1:0] long_thr_reg;
    logic [sbpc_pkg::THR_W-1:0] short_thr_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_thr_reg  <= sbpc_pkg::LONG_THR_RESET;
            short_thr_reg <= sbpc_pkg::SHORT_THR_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                sbpc_pkg::REG_LONG_THR:  long_thr_reg  <= pwdata[sbpc_pkg::THR_W-1:0];
                sbpc_pkg::REG_SHORT_THR: short_thr_reg <= pwdata[sbpc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            sbpc_pkg::REG_LONG_THR:  prdata = sbpc_pkg::DATA_W'(long_thr_reg);
            sbpc_pkg::REG_SHORT_THR: prdata = sbpc_pkg::DATA_W'(short_thr_reg);
            default:                 prdata = '0;
        endcase
    end

    assign thr.long_threshold  = long_thr_reg;
    assign thr.short_threshold = short_thr_reg;

endmodule

// ===== hdl/sbpc_core.sv =====
module sbpc_core
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbpc_pkg::thr_t        thr,
    sbpc_tick_if.sink             tick,
    sbpc_report_if.source         report
);

    localparam int CMP_W = (COUNT_BITS > sbpc_pkg::THR_W) ? COUNT_BITS : sbpc_pkg::THR_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // input stage
    logic s1_valid_reg;
    logic s1_level_reg;

    // scan state
    sbpc_pkg::phase_t        phase_reg, phase_next;
    logic                    seen_reg, seen_next;
    logic [2:0]              cand_reg, cand_next;
    logic [2:0]              latch_reg, latch_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;

    // result stage
    logic        out_valid_reg;
    logic [1:0]  phase_out_reg;
    logic        rvalid_reg, rvalid_next;
    logic [2:0]  btn_reg, btn_next;
    logic [1:0]  kind_reg, kind_next;

    logic advance;
    logic is_right;
    logic long_hit;
    logic short_hit;

    assign advance    = s1_valid_reg && (!out_valid_reg || report.ready);
    assign tick.ready = !s1_valid_reg || advance;
    assign is_right   = (phase_reg == sbpc_pkg::PH_RIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (tick.ready)
            s1_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
            s1_level_reg <= tick.sense_level;
    end

    always_comb
    begin
        logic [COUNT_BITS-1:0] cnt;
        seen_next  = seen_reg;
        cand_next  = cand_reg;
        latch_next = latch_reg;
        cnt        = count_reg;
        btn_next   = sbpc_pkg::BTN_NONE;
        kind_next  = sbpc_pkg::KIND_NONE;
        long_hit   = 1'b0;
        short_hit  = 1'b0;

        // button decode from the sensed level under this phase
        if (s1_level_reg)
        begin
            if (!seen_reg && phase_reg == sbpc_pkg::PH_CENTER)
                cand_next = sbpc_pkg::BTN_OUT;
            else if (is_right && cand_reg == sbpc_pkg::BTN_NONE && seen_reg)
                cand_next = sbpc_pkg::BTN_DEC;
            seen_next = 1'b1;
        end
        else if (seen_reg)
        begin
            if (phase_reg == sbpc_pkg::PH_CENTER)
                cand_next = sbpc_pkg::BTN_MODE;
            else if (is_right)
            begin
                if (cand_reg == sbpc_pkg::BTN_NONE)
                    cand_next = sbpc_pkg::BTN_INC;
                else
                begin
                    seen_next = 1'b0;
                    cand_next = sbpc_pkg::BTN_NONE;
                end
            end
        end
        else
        begin
            seen_next = 1'b0;
            cand_next = sbpc_pkg::BTN_NONE;
        end

        // classify on the right phase
        if (is_right)
        begin
            if (seen_next)
            begin
                if (cand_next == latch_reg)
                begin
                    if (cnt < COUNT_MAX)
                        cnt = cnt + 1'b1;
                    long_hit = CMP_W'(cnt) > CMP_W'(thr.long_threshold);
                    if (long_hit && latch_reg != sbpc_pkg::BTN_NONE)
                    begin
                        btn_next  = latch_reg;
                        kind_next = sbpc_pkg::KIND_LONG;
                    end
                end
                else
                begin
                    cnt        = COUNT_BITS'(1);
                    latch_next = cand_next;
                end
                cand_next = sbpc_pkg::BTN_NONE;
                seen_next = 1'b0;
            end
            else if (latch_reg != sbpc_pkg::BTN_NONE)
            begin
                long_hit  = CMP_W'(cnt) > CMP_W'(thr.long_threshold);
                short_hit = CMP_W'(cnt) > CMP_W'(thr.short_threshold);
                if (long_hit || short_hit)
                begin
                    kind_next = long_hit ? sbpc_pkg::KIND_RELEASE : sbpc_pkg::KIND_SHORT;
                    btn_next  = latch_reg;
                    cand_next = latch_reg;   // reported code stays as candidate
                end
                else
                    cand_next = sbpc_pkg::BTN_NONE;
                cnt        = '0;
                latch_next = sbpc_pkg::BTN_NONE;
                seen_next  = 1'b0;
            end
            else
            begin
                latch_next = sbpc_pkg::BTN_NONE;
                cnt        = '0;
            end
        end
        count_next  = cnt;
        rvalid_next = is_right;

        case (phase_reg)
            sbpc_pkg::PH_LEFT:   phase_next = sbpc_pkg::PH_CENTER;
            sbpc_pkg::PH_CENTER: phase_next = sbpc_pkg::PH_RIGHT;
            default:             phase_next = sbpc_pkg::PH_LEFT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sbpc_pkg::PH_LEFT;
            seen_reg  <= 1'b0;
            cand_reg  <= sbpc_pkg::BTN_NONE;
            latch_reg <= sbpc_pkg::BTN_NONE;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            cand_reg  <= cand_next;
            latch_reg <= latch_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            phase_out_reg <= phase_reg;
            rvalid_reg    <= rvalid_next;
            btn_reg       <= btn_next;
            kind_reg      <= kind_next;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.scan_phase   = phase_out_reg;
    assign report.report_valid = rvalid_reg;
    assign report.button_id    = btn_reg;
    assign report.press_kind   = kind_reg;

`ifndef NO_ASSERTIONS
    a_valid_right: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rvalid_reg) |-> (phase_out_reg == sbpc_pkg::PH_RIGHT))
        else $error("report flagged on a non-right phase");

    a_btn_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && btn_reg != sbpc_pkg::BTN_NONE) |->
        (kind_reg != sbpc_pkg::KIND_NONE && rvalid_reg))
        else $error("button reported without a press kind");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (phase_reg != $past(phase_reg)))
        else $error("scan phase did not advance");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("unused scan phase reached");
`endif

endmodule

// ===== hdl/scanned_button_press_classifier.sv =====
// Path: a tick passes the input register, then the result register, into a report.
// Throughput: one tick per cycle unless the report side stalls, which holds the tick
//   in the input register; scan state updates once per tick in a single pass.
// Reset: rst_n is asynchronous, active low; scan state clears to left phase with
//   no button, thresholds return to 250 and 2, both channels empty.
module scanned_button_press_classifier
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbpc_pkg::DATA_W-1:0]  pwdata,
    output logic [sbpc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    sbpc_tick_if.sink                    tick,
    sbpc_report_if.source                report
);

    sbpc_pkg::thr_t thr;

    sbpc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr     (thr)
    );

    sbpc_core #(.COUNT_BITS(COUNT_BITS)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .thr    (thr),
        .tick   (tick),
        .report (report)
    );

endmodule
